@@ sv/trps_pkg.sv @@
// Package for the timed reject pulse scheduler: field structs, sizes and codes.
// No dependencies.
package trps_pkg;

	localparam int CHANNELS_DEF    = 8;
	localparam int QUEUE_DEPTH_DEF = 32;
	localparam int PORTS_DEF       = 16;
	localparam int PORT_SLOTS      = 16;

	localparam logic [15:0] PULSE_WIDTH_RST = 16'd2;
	localparam logic [15:0] HOLDOFF_RST     = 16'd4;

	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_ENQ   = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;
	localparam logic [1:0] REQ_WRITE = 2'd3;

	localparam logic REG_PULSE_WIDTH = 1'b0;
	localparam logic REG_HOLDOFF     = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [2:0]  channel;
		logic [3:0]  port;
		logic [31:0] due_time;
		logic        level;
	} req_t;

	typedef struct packed {
		logic [15:0] port_levels;
		logic        overflow;
		logic [31:0] time_now;
	} rsp_t;

	// one queue entry: port and time stamp
	typedef struct packed {
		logic [3:0]  port;
		logic [31:0] stamp;
	} entry_t;

endpackage

@@ sv/timed_reject_pulse_scheduler_core.sv @@
// Top level of the timed reject pulse scheduler: sequencer, queue memories, port state.
// Depends on trps_pkg.
//
//  channel  | direction | handshake            | payload
//  request  | in        | start / busy         | req (req_t)
//  result   | out       | done strobe, 1 cycle | rsp (rsp_t)
//  config   | in        | cfg_we               | cfg_idx, cfg_wdata
//
// Enqueue, clear and port write go from acceptance through ST_OP to the done beat in ST_DONE.
// A tick walks the channels down from CHANNELS-1 through ST_FRD, ST_FCHK, ST_PRD,
// ST_PCHK, ST_NEXT: one head read per single-port memory and up to two writes.
// Queue contents need no clearing; pointers, levels and fire times reset at once.
// busy is high from acceptance until the done beat; the result cannot be stalled.
module timed_reject_pulse_scheduler_core #(
	parameter int CHANNELS    = trps_pkg::CHANNELS_DEF,
	parameter int QUEUE_DEPTH = trps_pkg::QUEUE_DEPTH_DEF,
	parameter int PORTS       = trps_pkg::PORTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  trps_pkg::req_t   req,
	output logic             busy,
	output logic             done,
	output trps_pkg::rsp_t   rsp,
	input  logic             cfg_we,
	input  logic             cfg_idx,
	input  logic [15:0]      cfg_wdata
);
	import trps_pkg::*;

	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);
	localparam int MW = CW + AW;
	localparam int MD = 1 << MW;
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [NW-1:0] FULL = NW'(QUEUE_DEPTH);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_OP    = 4'd1;
	localparam logic [3:0] ST_FRD   = 4'd2;  // read fired head
	localparam logic [3:0] ST_FCHK  = 4'd3;  // fired data back, decide
	localparam logic [3:0] ST_PRD   = 4'd4;  // read pending head
	localparam logic [3:0] ST_PCHK  = 4'd5;  // pending data back, decide
	localparam logic [3:0] ST_NEXT  = 4'd6;
	localparam logic [3:0] ST_DONE  = 4'd7;

	entry_t pend_mem [MD];
	entry_t fire_mem [MD];
	entry_t pend_rd_q, fire_rd_q;

	logic [AW-1:0] phead_q [CHANNELS];
	logic [NW-1:0] pcnt_q  [CHANNELS];
	logic [AW-1:0] fhead_q [CHANNELS];
	logic [NW-1:0] fcnt_q  [CHANNELS];
	logic [31:0]   last_fire_q [PORT_SLOTS];

	logic [3:0]    state_q;
	req_t          req_q;
	logic [CW-1:0] ch_q;
	logic [15:0]   width_q, holdoff_q;
	logic [31:0]   tick_q;
	logic [15:0]   levels_q;
	logic          ovf_q;

	// memory port controls
	logic          p_we, p_re, f_we, f_re;
	logic [MW-1:0] p_addr, f_addr;
	entry_t        p_wd, f_wd;

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] h, logic [NW-1:0] n);
		logic [AW:0] s;
		begin
			s = {1'b0, h} + (AW+1)'(n);
			if (s >= (AW+1)'(QUEUE_DEPTH))
				s = s - (AW+1)'(QUEUE_DEPTH);
			return s[AW-1:0];
		end
	endfunction

	function automatic logic [AW-1:0] inc(logic [AW-1:0] h);
		return (h == LAST) ? '0 : h + 1'b1;
	endfunction

	function automatic logic [MW-1:0] maddr(logic [CW-1:0] c, logic [AW-1:0] a);
		return MW'({c, a});
	endfunction

	logic req_ch_ok;
	assign req_ch_ok = ({1'b0, req_q.channel} < 4'(CHANNELS));
	logic [CW-1:0] req_ch;
	assign req_ch = req_q.channel[CW-1:0];

	logic fdue, pready;
	logic [31:0] lf;
	assign fdue   = (tick_q - fire_rd_q.stamp) >= {16'd0, width_q};
	assign lf     = last_fire_q[pend_rd_q.port];
	assign pready = !(tick_q < pend_rd_q.stamp) &&
	                ((tick_q - lf) > {16'd0, holdoff_q});

	always_comb begin
		p_we = 1'b0; p_re = 1'b0; f_we = 1'b0; f_re = 1'b0;
		p_addr = '0; f_addr = '0;
		p_wd = '0; f_wd = '0;
		case (state_q)
			ST_OP: begin
				if (req_q.req_type == REQ_ENQ && req_ch_ok && pcnt_q[req_ch] != FULL) begin
					p_we = 1'b1;
					p_addr = maddr(req_ch, wrap_add(phead_q[req_ch], pcnt_q[req_ch]));
					p_wd = '{port: req_q.port, stamp: req_q.due_time};
				end
			end
			ST_FRD: begin
				f_re = 1'b1;
				f_addr = maddr(ch_q, fhead_q[ch_q]);
			end
			ST_FCHK: begin
				// requeue: head is popped in this state, so write at new head plus count minus one
				if (fcnt_q[ch_q] != '0 && !fdue) begin
					f_we = 1'b1;
					f_addr = maddr(ch_q, wrap_add(inc(fhead_q[ch_q]), fcnt_q[ch_q] - 1'b1));
					f_wd = fire_rd_q;
				end
			end
			ST_PRD: begin
				p_re = 1'b1;
				p_addr = maddr(ch_q, phead_q[ch_q]);
			end
			ST_PCHK: begin
				if (pcnt_q[ch_q] != '0) begin
					if (!pready) begin
						p_we = 1'b1;
						p_addr = maddr(ch_q, wrap_add(inc(phead_q[ch_q]), pcnt_q[ch_q] - 1'b1));
						p_wd = pend_rd_q;
					end else if (fcnt_q[ch_q] != FULL) begin
						f_we = 1'b1;
						f_addr = maddr(ch_q, wrap_add(fhead_q[ch_q], fcnt_q[ch_q]));
						f_wd = '{port: pend_rd_q.port, stamp: tick_q};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (p_we)
			pend_mem[p_addr] <= p_wd;
		if (p_re)
			pend_rd_q <= pend_mem[p_addr];
		if (f_we)
			fire_mem[f_addr] <= f_wd;
		if (f_re)
			fire_rd_q <= fire_mem[f_addr];
	end

	always_ff @(posedge clk) begin
		if (start && !busy)
			req_q <= req;
	end

	function automatic logic [15:0] set_lvl(logic [15:0] v, logic [3:0] p, logic on);
		logic [15:0] r;
		begin
			r = v;
			if ({1'b0, p} < 5'(PORTS))
				r[p] = on;
			return r;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ch_q      <= '0;
			width_q   <= PULSE_WIDTH_RST;
			holdoff_q <= HOLDOFF_RST;
			tick_q    <= '0;
			levels_q  <= '0;
			ovf_q     <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				phead_q[i] <= '0; pcnt_q[i] <= '0;
				fhead_q[i] <= '0; fcnt_q[i] <= '0;
			end
			for (int i = 0; i < PORT_SLOTS; i++)
				last_fire_q[i] <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_PULSE_WIDTH)
					width_q <= cfg_wdata;
				else
					holdoff_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (start)
						state_q <= ST_OP;
				end
				ST_OP: begin
					ovf_q   <= (req_q.req_type == REQ_ENQ) && req_ch_ok &&
					           (pcnt_q[req_ch] == FULL);
					state_q <= (req_q.req_type == REQ_TICK) ? ST_FRD : ST_DONE;
					case (req_q.req_type)
						REQ_TICK: begin
							tick_q  <= tick_q + 1'b1;
							ch_q    <= CW'(CHANNELS - 1);
						end
						REQ_ENQ: begin
							if (req_ch_ok) begin
								if (pcnt_q[req_ch] != FULL)
									pcnt_q[req_ch] <= pcnt_q[req_ch] + 1'b1;
								else begin
									phead_q[req_ch] <= inc(phead_q[req_ch]);
									pcnt_q[req_ch]  <= pcnt_q[req_ch] - 1'b1;
								end
							end
						end
						REQ_CLEAR: begin
							if (req_ch_ok) begin
								phead_q[req_ch] <= '0; pcnt_q[req_ch] <= '0;
								fhead_q[req_ch] <= '0; fcnt_q[req_ch] <= '0;
							end
						end
						default: levels_q <= set_lvl(levels_q, req_q.port, req_q.level);
					endcase
				end
				ST_FRD: state_q <= ST_FCHK;
				ST_FCHK: begin
					if (fcnt_q[ch_q] != '0) begin
						fhead_q[ch_q] <= inc(fhead_q[ch_q]);
						if (fdue) begin
							fcnt_q[ch_q] <= fcnt_q[ch_q] - 1'b1;
							levels_q <= set_lvl(levels_q, fire_rd_q.port, 1'b0);
						end
					end
					state_q <= ST_PRD;
				end
				ST_PRD: state_q <= ST_PCHK;
				ST_PCHK: begin
					if (pcnt_q[ch_q] != '0) begin
						phead_q[ch_q] <= inc(phead_q[ch_q]);
						if (pready) begin
							pcnt_q[ch_q] <= pcnt_q[ch_q] - 1'b1;
							levels_q <= set_lvl(levels_q, pend_rd_q.port, 1'b1);
							last_fire_q[pend_rd_q.port] <= tick_q;
							if (fcnt_q[ch_q] != FULL)
								fcnt_q[ch_q] <= fcnt_q[ch_q] + 1'b1;
						end
					end
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (ch_q == '0)
						state_q <= ST_DONE;
					else begin
						ch_q    <= ch_q - 1'b1;
						state_q <= ST_FRD;
					end
				end
				ST_DONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign rsp  = '{port_levels: levels_q, overflow: ovf_q, time_now: tick_q};

endmodule
